FILE: src/stc_pkg.sv
// shared types, constants and helper functions for the smpte timecode counter
// no dependencies; imported by every module of the block
package stc_pkg;

  // request kinds carried in tuser
  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_LOAD    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAMES_PER_SECOND = 2'd0;
  localparam logic [1:0] CFG_DROP_FRAME        = 2'd1;
  localparam logic [1:0] CFG_DATE_MODE         = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  // configuration reset values
  localparam logic [4:0] FPS_RESET        = 5'd30;
  localparam logic       DROP_FRAME_RESET = 1'b0;
  localparam logic       DATE_MODE_RESET  = 1'b1;

  // load saturation limits
  localparam logic [6:0] HOURS_TOP   = 7'd99;
  localparam logic [5:0] MINUTES_TOP = 6'd59;
  localparam logic [5:0] SECONDS_TOP = 6'd59;
  localparam logic [4:0] FRAME_TOP   = 5'd29;
  localparam logic [6:0] YEAR_TOP    = 7'd99;
  localparam logic [3:0] MONTH_TOP   = 4'd12;
  localparam logic [4:0] DAY_TOP     = 5'd31;

  // counter wrap points
  localparam logic [6:0] SIXTY          = 7'd60;
  localparam logic [6:0] HOURS_PER_DAY  = 7'd24;
  localparam logic [6:0] HOURS_WRAP     = 7'd100;
  localparam logic [3:0] MONTH_FIRST    = 4'd1;
  localparam logic [3:0] MONTH_LAST     = 4'd12;
  localparam logic [4:0] DAY_FIRST      = 5'd1;
  localparam logic [6:0] YEAR_LAST      = 7'd99;
  localparam logic [4:0] DROP_FRAME_NUM = 5'd2;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [4:0] frames_per_second;
    logic       drop_frame;
    logic       date_mode;
  } cfg_t;

  // input payload, last field in the lowest bits
  typedef struct packed {
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
    logic [4:0] load_frame_number;
    logic [5:0] load_seconds;
    logic [5:0] load_minutes;
    logic [6:0] load_hours;
  } load_t;

  // timecode held as binary counts
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frame;
  } tc_t;

  // result payload in bcd, last field in the lowest bits
  typedef struct packed {
    logic [7:0] out_year_bcd;
    logic [4:0] out_month_bcd;
    logic [5:0] out_day_bcd;
    logic [7:0] out_hours_bcd;
    logic [6:0] out_minutes_bcd;
    logic [6:0] out_seconds_bcd;
    logic [5:0] out_frame_bcd;
  } bcd_t;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - $bits(bcd_t);

  // binary 0..99 to two bcd digits, tens found by independent compares
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    units = v - 7'(7'(tens) * 7'd10);
    return {tens, units[3:0]};
  endfunction

  // days in a month, february by leap flag
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/stc_cfg_regs.sv
// configuration registers of the timecode counter
// depends on stc_pkg for register indexes and reset values
module stc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output stc_pkg::cfg_t                  cfg
);
  import stc_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register write decode, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frames_per_second <= FPS_RESET;
      cfg.drop_frame        <= DROP_FRAME_RESET;
      cfg.date_mode         <= DATE_MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAMES_PER_SECOND: cfg.frames_per_second <= cfg_data;
        CFG_DROP_FRAME:        cfg.drop_frame        <= cfg_data[0];
        CFG_DATE_MODE:         cfg.date_mode         <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/stc_step.sv
// next-timecode logic: load or frame advance, date step, drop-frame fixup
// depends on stc_pkg for types, limits and bcd helpers
module stc_step (
  input  stc_pkg::cfg_t  cfg,
  input  logic           req_type,
  input  stc_pkg::load_t load,
  input  stc_pkg::tc_t   st,
  output stc_pkg::tc_t   st_next,
  output stc_pkg::bcd_t  bcd_next
);
  import stc_pkg::*;

  logic       leap;
  logic       month_ok;
  logic [4:0] len;
  logic [5:0] day_inc;
  logic [6:0] year_n;
  logic [3:0] month_n;
  logic [4:0] day_n;
  logic [5:0] frame_inc;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [6:0] hour_inc;
  logic [7:0] min_bcd;
  tc_t        nx;

  // calendar step taken on a day wrap
  assign leap     = (st.year[1:0] == 2'b00) && (st.year != '0);
  assign month_ok = (st.month >= MONTH_FIRST) && (st.month <= MONTH_LAST);
  assign len      = month_days(st.month, leap);
  assign day_inc  = {1'b0, st.day} + 6'd1;

  always_comb begin
    year_n  = st.year;
    month_n = st.month;
    day_n   = st.day;
    if (month_ok) begin
      if (day_inc > {1'b0, len}) begin
        day_n = DAY_FIRST;
        if (st.month == MONTH_LAST) begin
          month_n = MONTH_FIRST;
          year_n  = (st.year == YEAR_LAST) ? '0 : st.year + 7'd1;
        end else begin
          month_n = st.month + 4'd1;
        end
      end else begin
        day_n = day_inc[4:0];
      end
    end
  end

  // cascaded counters
  assign frame_inc = {1'b0, st.frame} + 6'd1;
  assign sec_inc   = {1'b0, st.seconds} + 7'd1;
  assign min_inc   = {1'b0, st.minutes} + 7'd1;
  assign hour_inc  = st.hours + 7'd1;

  always_comb begin
    nx = st;
    if (req_type == REQ_LOAD) begin
      nx.hours   = (load.load_hours > HOURS_TOP) ? HOURS_TOP : load.load_hours;
      nx.minutes = (load.load_minutes > MINUTES_TOP) ? MINUTES_TOP : load.load_minutes;
      nx.seconds = (load.load_seconds > SECONDS_TOP) ? SECONDS_TOP : load.load_seconds;
      nx.frame   = (load.load_frame_number > FRAME_TOP) ? FRAME_TOP
                                                        : load.load_frame_number;
      nx.year    = (load.load_year > YEAR_TOP) ? YEAR_TOP : load.load_year;
      nx.month   = (load.load_month > MONTH_TOP) ? MONTH_TOP : load.load_month;
      nx.day     = (load.load_day > DAY_TOP) ? DAY_TOP : load.load_day;
    end else if (frame_inc < {1'b0, cfg.frames_per_second}) begin
      nx.frame = frame_inc[4:0];
    end else begin
      nx.frame = '0;
      if (sec_inc < SIXTY) begin
        nx.seconds = sec_inc[5:0];
      end else begin
        nx.seconds = '0;
        if (min_inc < SIXTY) begin
          nx.minutes = min_inc[5:0];
        end else begin
          nx.minutes = '0;
          nx.hours   = hour_inc;
          if (cfg.date_mode) begin
            if (hour_inc >= HOURS_PER_DAY) begin
              nx.hours = '0;
              nx.year  = year_n;
              nx.month = month_n;
              nx.day   = day_n;
            end
          end else if (hour_inc >= HOURS_WRAP) begin
            nx.hours = '0;
          end
        end
      end
    end
  end

  // drop-frame: skip frames 0 and 1 at minutes not a multiple of ten
  assign min_bcd = bin_to_bcd({1'b0, nx.minutes});

  always_comb begin
    st_next = nx;
    if (cfg.drop_frame && (min_bcd[3:0] != 4'd0) && (nx.seconds == '0) &&
        (nx.frame == '0)) begin
      st_next.frame = DROP_FRAME_NUM;
    end
  end

  // bcd view of the new timecode
  logic [7:0] frame_b, sec_b, hour_b, day_b, month_b, year_b;
  assign frame_b = bin_to_bcd({2'b00, st_next.frame});
  assign sec_b   = bin_to_bcd({1'b0, st_next.seconds});
  assign hour_b  = bin_to_bcd(st_next.hours);
  assign day_b   = bin_to_bcd({2'b00, st_next.day});
  assign month_b = bin_to_bcd({3'b000, st_next.month});
  assign year_b  = bin_to_bcd(st_next.year);

  assign bcd_next.out_frame_bcd   = frame_b[5:0];
  assign bcd_next.out_seconds_bcd = sec_b[6:0];
  assign bcd_next.out_minutes_bcd = min_bcd[6:0];
  assign bcd_next.out_hours_bcd   = hour_b;
  assign bcd_next.out_day_bcd     = day_b[5:0];
  assign bcd_next.out_month_bcd   = month_b[4:0];
  assign bcd_next.out_year_bcd    = year_b;

endmodule

FILE: src/smpte_timecode_counter_top.sv
// top level of the smpte timecode counter: input register, state, result register
// depends on stc_pkg, stc_cfg_regs and stc_step
//
// usage:
//   s_axis carries one request word: tuser is the request kind (0 advance one
//   frame, 1 load), tdata holds the binary load fields. every accepted word
//   produces exactly one m_axis word holding the updated timecode in bcd.
//   cfg_valid/cfg_index/cfg_data write the rate, drop-frame and date-mode
//   registers; cfg_ready is always high. write them only while the block is idle.
// data flow and throughput:
//   a word waits in the input register, then the next-timecode logic
//   updates the state and the result register in the same edge. one word per
//   cycle is sustained while m_axis_tready stays high; the limit is the state
//   update loop through stc_step.
// reset:
//   rst clears the timecode to all zeros, empties both registers and restores
//   30 frames per second, drop-frame off, date mode on.
// stall:
//   while a result waits with m_axis_tready low, it holds, the state stops, and
//   an empty input register takes one more word before s_axis_tready drops.
module smpte_timecode_counter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // request word
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: load_hours, load_minutes, load_seconds, load_frame_number,
  //        load_year, load_month, load_day
  input  logic [stc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // tuser: req_type
  input  logic                                 s_axis_tuser,
  // result word
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: out_frame_bcd, out_seconds_bcd, out_minutes_bcd, out_hours_bcd,
  //        out_day_bcd, out_month_bcd, out_year_bcd, one zero pad bit
  output logic [stc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import stc_pkg::*;

  cfg_t  cfg;
  logic  in_valid;
  logic  in_req;
  load_t in_load;
  tc_t   st;
  tc_t   st_next;
  bcd_t  bcd_next;
  bcd_t  res;
  logic  adv;

  stc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stc_step u_step (
    .cfg      (cfg),
    .req_type (in_req),
    .load     (in_load),
    .st       (st),
    .st_next  (st_next),
    .bcd_next (bcd_next)
  );

  // handshake: move a word on whenever the result slot is free or draining
  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= s_axis_tuser;
      in_load <= load_t'(s_axis_tdata);
    end
  end

  // timecode state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= bcd_next;
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res};

  // a stalled result freezes the timecode
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(st))
    else $error("timecode changed while result stalled");

  // input side only blocks when a word is waiting
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid))
    else $error("input blocked with an empty register");

  // frame count never reaches 31
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    st.frame != 5'd31)
    else $error("frame count out of range");

  // with drop-frame on, no produced result shows a dropped frame 0
  a_drop_applied: assert property (@(posedge clk) disable iff (rst)
    (adv && cfg.drop_frame) |=>
      !((res.out_frame_bcd == '0) && (res.out_seconds_bcd == '0) &&
        (res.out_minutes_bcd[3:0] != 4'd0)))
    else $error("drop-frame numbering not applied");

endmodule

FILE: bench/smpte_timecode_counter_checker.sv
`timescale 1ns / 100ps
// timecode checker: watches request, result and register-write channels of the
// timecode counter, predicts every result word and compares it field by field
// depends on stc_pkg
module smpte_timecode_counter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [stc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [stc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [stc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import stc_pkg::*;

  // register copies and the predicted timecode, held as binary counts
  logic [4:0] rate;
  logic       drop_on;
  logic       date_on;
  tc_t        clock_now;
  bcd_t       expected_timecodes[$];
  int         errs;

  function automatic logic [7:0] two_digits(input int v);
    logic [7:0] r;
    r[7:4] = 4'(v / 10);
    r[3:0] = 4'(v % 10);
    return r;
  endfunction

  function automatic int cap(input int v, input int top);
    return (v > top) ? top : v;
  endfunction

  // days in month m of year y, leap february when y is a nonzero multiple of 4
  function automatic int days_in(input int m, input int y);
    case (m)
      2:           return (y % 4 == 0 && y != 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // one calendar day forward; a month outside 1..12 freezes the date
  function automatic void roll_calendar();
    int y, m, d;
    y = int'(clock_now.year);
    m = int'(clock_now.month);
    d = int'(clock_now.day);
    if (m < 1 || m > 12) return;
    d++;
    if (d > days_in(m, y)) begin
      d = 1;
      m++;
      if (m > 12) begin
        m = 1;
        y = (y + 1) % 100;
      end
    end
    clock_now.year  = 7'(y);
    clock_now.month = 4'(m);
    clock_now.day   = 5'(d);
  endfunction

  // one frame forward, carrying up to hours and, in date mode, the date
  function automatic void count_frame();
    int f, s, mi, h, rate_i;
    rate_i = int'(rate);
    f = int'(clock_now.frame) + 1;
    if (f < rate_i) begin
      clock_now.frame = 5'(f);
      return;
    end
    clock_now.frame = '0;
    s = int'(clock_now.seconds) + 1;
    if (s < 60) begin
      clock_now.seconds = 6'(s);
      return;
    end
    clock_now.seconds = '0;
    mi = int'(clock_now.minutes) + 1;
    if (mi < 60) begin
      clock_now.minutes = 6'(mi);
      return;
    end
    clock_now.minutes = '0;
    h = int'(clock_now.hours) + 1;
    if (date_on) begin
      if (h >= 24) begin
        h = 0;
        roll_calendar();
      end
    end else if (h >= 100) begin
      h = 0;
    end
    clock_now.hours = 7'(h);
  endfunction

  // apply one request and return the timecode word it should produce
  function automatic bcd_t next_timecode(input logic kind, input load_t req);
    bcd_t r;
    if (kind == REQ_LOAD) begin
      clock_now.hours   = 7'(cap(int'(req.load_hours), 99));
      clock_now.minutes = 6'(cap(int'(req.load_minutes), 59));
      clock_now.seconds = 6'(cap(int'(req.load_seconds), 59));
      clock_now.frame   = 5'(cap(int'(req.load_frame_number), 29));
      clock_now.year    = 7'(cap(int'(req.load_year), 99));
      clock_now.month   = 4'(cap(int'(req.load_month), 12));
      clock_now.day     = 5'(cap(int'(req.load_day), 31));
    end else begin
      count_frame();
    end
    // drop-frame skip at the top of a minute whose units digit is nonzero
    if (drop_on && int'(clock_now.minutes) % 10 != 0 && clock_now.seconds == '0 &&
        clock_now.frame == '0)
      clock_now.frame = 5'd2;
    r.out_frame_bcd   = 6'(two_digits(int'(clock_now.frame)));
    r.out_seconds_bcd = 7'(two_digits(int'(clock_now.seconds)));
    r.out_minutes_bcd = 7'(two_digits(int'(clock_now.minutes)));
    r.out_hours_bcd   = two_digits(int'(clock_now.hours));
    r.out_day_bcd     = 6'(two_digits(int'(clock_now.day)));
    r.out_month_bcd   = 5'(two_digits(int'(clock_now.month)));
    r.out_year_bcd    = two_digits(int'(clock_now.year));
    return r;
  endfunction

  function automatic int field_diff(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    bcd_t  got, want;
    load_t req;
    if (rst) begin
      rate      = FPS_RESET;
      drop_on   = DROP_FRAME_RESET;
      date_on   = DATE_MODE_RESET;
      clock_now = '0;
      errs      = 0;
      expected_timecodes.delete();
    end else begin
      // result word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(bcd_t)-1:0];
        if (expected_timecodes.size() == 0) begin
          $error("result word %h with no request outstanding", got);
          errs++;
        end else begin
          want = expected_timecodes.pop_front();
          errs += field_diff("out_frame_bcd", int'(want.out_frame_bcd),
                             int'(got.out_frame_bcd));
          errs += field_diff("out_seconds_bcd", int'(want.out_seconds_bcd),
                             int'(got.out_seconds_bcd));
          errs += field_diff("out_minutes_bcd", int'(want.out_minutes_bcd),
                             int'(got.out_minutes_bcd));
          errs += field_diff("out_hours_bcd", int'(want.out_hours_bcd),
                             int'(got.out_hours_bcd));
          errs += field_diff("out_day_bcd", int'(want.out_day_bcd),
                             int'(got.out_day_bcd));
          errs += field_diff("out_month_bcd", int'(want.out_month_bcd),
                             int'(got.out_month_bcd));
          errs += field_diff("out_year_bcd", int'(want.out_year_bcd),
                             int'(got.out_year_bcd));
          errs += field_diff("pad", 0, int'(m_axis_tdata[OUT_DATA_W-1:$bits(bcd_t)]));
        end
      end
      // request word
      if (s_axis_tvalid && s_axis_tready) begin
        req = s_axis_tdata[$bits(load_t)-1:0];
        expected_timecodes.push_back(next_timecode(s_axis_tuser, req));
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAMES_PER_SECOND: rate    = cfg_data;
          CFG_DROP_FRAME:        drop_on = cfg_data[0];
          CFG_DATE_MODE:         date_on = cfg_data[0];
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    pending    <= expected_timecodes.size();
  end

endmodule

FILE: bench/smpte_timecode_counter_top_tb.sv
`timescale 1ns / 100ps
// testbench top for the timecode counter: clock, reset, request and register
// stimulus, result-side back-pressure and the final verdict
// depends on stc_pkg, smpte_timecode_counter_top and smpte_timecode_counter_checker
module smpte_timecode_counter_top_tb;
  import stc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 130;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          mismatches;
  int          pending;
  bit          gaps_on = 1'b1;
  int          load_words;
  int          advance_words;
  int          settings_used;
  int unsigned cycles;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  smpte_timecode_counter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  smpte_timecode_counter_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall before each word
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = gaps_on ? $urandom_range(0, 10) : 0;
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // one request word after a random gap; valid stays high on return
  task automatic send_request(input logic kind, input load_t fields);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_DATA_W'(fields);
    do @(posedge clk); while (!s_axis_tready);
    if (kind == REQ_LOAD) load_words++;
    else advance_words++;
  endtask

  function automatic load_t random_fields();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(load_t)-1:0];
  endfunction

  task automatic load_time(input int h, input int mi, input int s, input int f,
                           input int y, input int mo, input int d);
    load_t w;
    w.load_hours        = 7'(h);
    w.load_minutes      = 6'(mi);
    w.load_seconds      = 6'(s);
    w.load_frame_number = 5'(f);
    w.load_year         = 7'(y);
    w.load_month        = 4'(mo);
    w.load_day          = 5'(d);
    send_request(REQ_LOAD, w);
  endtask

  // advance payload is ignored, so it carries random bits
  task automatic advance_frames(input int n);
    repeat (n) send_request(REQ_ADVANCE, random_fields());
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // rate, drop-frame and date mode; unused upper bits of the flags are random
  task automatic apply_settings(input int fps, input int drop, input int date);
    drain();
    write_reg(CFG_FRAMES_PER_SECOND, 5'(fps));
    write_reg(CFG_DROP_FRAME, {4'($urandom()), 1'(drop)});
    write_reg(CFG_DATE_MODE, {4'($urandom()), 1'(date)});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // random traffic: mostly loads just short of a rollover, then a few frames
  task automatic random_phase(input int fps);
    int sent, pick, h, mi, s, f, y, mo, d, n;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      if ($urandom_range(0, 39) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        case ($urandom_range(0, 3))
          0:       h = 23;
          1:       h = 99;
          default: h = $urandom_range(0, 99);
        endcase
        case ($urandom_range(0, 3))
          0:       mi = 9;
          1:       mi = $urandom_range(0, 59);
          default: mi = 59;
        endcase
        case ($urandom_range(0, 3))
          0:       s = 0;
          1:       s = $urandom_range(0, 59);
          default: s = 59;
        endcase
        case ($urandom_range(0, 3))
          0:       f = 0;
          1:       f = $urandom_range(0, 29);
          2:       f = 29;
          default: f = (fps > 0 && fps <= 30) ? fps - 1 : 29;
        endcase
        case ($urandom_range(0, 3))
          0:       y = 4 * $urandom_range(0, 24);
          1:       y = 99;
          default: y = $urandom_range(0, 99);
        endcase
        mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 12);
        d  = ($urandom_range(0, 1) == 0) ? $urandom_range(28, 31) : $urandom_range(0, 31);
        load_time(h, mi, s, f, y, mo, d);
        n = $urandom_range(1, 6);
        advance_frames(n);
        sent += 1 + n;
      end else if (pick < 9) begin
        // raw load, fields may exceed their ranges
        send_request(REQ_LOAD, random_fields());
        sent++;
      end else begin
        advance_frames(1);
        sent++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ADVANCE;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_FRAMES_PER_SECOND;
    cfg_data      = '0;
    cycles        = 0;
    load_words    = 0;
    advance_words = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, calendar corners
    load_time(0, 0, 0, 0, 0, 0, 0);
    advance_frames(1);
    load_time(23, 59, 59, 29, 99, 12, 31);      // end of century
    advance_frames(1);
    load_time(127, 63, 63, 31, 127, 15, 31);    // every field but the day saturates
    advance_frames(1);
    load_time(23, 59, 59, 29, 50, 0, 15);       // month zero freezes the date
    advance_frames(1);
    load_time(23, 59, 59, 29, 4, 2, 28);        // leap february
    advance_frames(1);
    load_time(23, 59, 59, 29, 4, 2, 29);
    advance_frames(1);
    load_time(23, 59, 59, 29, 0, 2, 28);        // year zero is not leap
    advance_frames(1);
    load_time(23, 59, 59, 29, 7, 4, 31);        // day past a 30-day month
    advance_frames(1);
    load_time(23, 59, 59, 29, 7, 6, 0);         // day zero becomes one
    advance_frames(1);

    // directed: drop-frame numbering
    apply_settings(30, 1, 1);
    load_time(0, 0, 59, 29, 1, 1, 1);
    advance_frames(1);
    load_time(0, 9, 59, 29, 1, 1, 1);           // tenth minute keeps frame zero
    advance_frames(1);
    load_time(0, 1, 0, 0, 1, 1, 1);             // load lands on a dropped frame

    // directed: zero rate, hours wrap at 100
    apply_settings(0, 0, 0);
    load_time(99, 59, 59, 29, 3, 3, 3);
    advance_frames(2);

    // random phases, register extremes among them
    apply_settings(30, 0, 1);
    random_phase(30);
    apply_settings(1, 1, 1);
    random_phase(1);
    apply_settings(25, 0, 0);
    random_phase(25);
    apply_settings(0, 1, 1);
    random_phase(0);
    apply_settings(31, 0, 1);
    random_phase(31);
    apply_settings(24, 1, 0);
    random_phase(24);
    begin : last_phase
      int fps;
      fps = $urandom_range(1, 30);
      apply_settings(fps, $urandom_range(0, 1), $urandom_range(0, 1));
      random_phase(fps);
    end

    drain();
    repeat (10) @(negedge clk);
    $display("%0d loads and %0d frame advances checked under %0d register settings",
             load_words, advance_words, settings_used);
    $display("rates 0, 1, 24, 25, 30, 31; drop-frame and date mode both ways");
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
